@@ hw/rtl/tt_pkg.sv @@
package tt_pkg;

	typedef enum logic [2:0] {
		MODE_SKIP,
		MODE_SLASH,
		MODE_COMMENT,
		MODE_QUOTE,
		MODE_WORD,
		MODE_DONE
	} tt_mode_t;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_NUL   = 8'h00;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	// one queued job: an optional pending '/' beat, then the main beat
	typedef struct packed {
		logic       slash;
		logic [7:0] tbyte;
		logic       bval;
		logic       tend;
		logic       send;
	} tt_job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} tt_qstat_t;

endpackage

@@ hw/rtl/tt_front.sv @@
module tt_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  logic [7:0]     text_byte,
	input  logic           signed_chars,
	output logic           push,
	output tt_pkg::tt_job_t job
);
	import tt_pkg::*;

	tt_mode_t mode_q, mode_d;
	logic     blank;
	tt_job_t  word_job;
	logic     emit;

	assign blank = (text_byte <= CH_SPACE) || (signed_chars && text_byte[7]);

	// result of a byte that follows word characters or a pending slash
	always_comb begin
		word_job = '0;
		if (!blank) begin
			word_job.tbyte = text_byte;
			word_job.bval  = 1'b1;
		end else if (text_byte == CH_NUL) begin
			word_job.tend = 1'b1;
			word_job.send = 1'b1;
		end else begin
			word_job.tend = 1'b1;
		end
	end

	always_comb begin
		mode_d = mode_q;
		unique case (mode_q)
			MODE_SKIP: begin
				if (text_byte == CH_NUL)        mode_d = MODE_DONE;
				else if (blank)                 mode_d = MODE_SKIP;
				else if (text_byte == CH_SLASH) mode_d = MODE_SLASH;
				else if (text_byte == CH_QUOTE) mode_d = MODE_QUOTE;
				else                            mode_d = MODE_WORD;
			end
			MODE_SLASH, MODE_WORD: begin
				if (mode_q == MODE_SLASH && text_byte == CH_SLASH) mode_d = MODE_COMMENT;
				else if (!blank)                                  mode_d = MODE_WORD;
				else if (text_byte == CH_NUL)                     mode_d = MODE_DONE;
				else                                              mode_d = MODE_SKIP;
			end
			MODE_COMMENT: begin
				if (text_byte == CH_NUL)     mode_d = MODE_DONE;
				else if (text_byte == CH_NL) mode_d = MODE_SKIP;
			end
			MODE_QUOTE: begin
				if (text_byte == CH_NUL)        mode_d = MODE_DONE;
				else if (text_byte == CH_QUOTE) mode_d = MODE_SKIP;
			end
			default: mode_d = MODE_DONE;
		endcase
	end

	always_comb begin
		job  = '0;
		emit = 1'b0;
		unique case (mode_q)
			MODE_SKIP: begin
				if (text_byte == CH_NUL) begin
					emit     = 1'b1;
					job.send = 1'b1;
				end else if (!blank && text_byte != CH_SLASH && text_byte != CH_QUOTE) begin
					emit      = 1'b1;
					job.tbyte = text_byte;
					job.bval  = 1'b1;
				end
			end
			MODE_SLASH: begin
				if (text_byte != CH_SLASH) begin
					emit      = 1'b1;
					job       = word_job;
					job.slash = 1'b1;
				end
			end
			MODE_COMMENT: begin
				if (text_byte == CH_NUL) begin
					emit     = 1'b1;
					job.send = 1'b1;
				end
			end
			MODE_QUOTE: begin
				emit = 1'b1;
				if (text_byte == CH_NUL) begin
					job.tend = 1'b1;
					job.send = 1'b1;
				end else if (text_byte == CH_QUOTE) begin
					job.tend = 1'b1;
				end else begin
					job.tbyte = text_byte;
					job.bval  = 1'b1;
				end
			end
			MODE_WORD: begin
				emit = 1'b1;
				job  = word_job;
			end
			default: emit = 1'b0;
		endcase
	end

	assign push = accept && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SKIP;
		end else if (accept) begin
			mode_q <= mode_d;
		end
	end

endmodule

@@ hw/rtl/tt_queue.sv @@
module tt_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  tt_pkg::tt_job_t   wr_job,
	input  logic              pop,
	output tt_pkg::tt_job_t   head,
	output tt_pkg::tt_qstat_t stat
);
	import tt_pkg::*;

	tt_job_t        mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QAW:0]   count_q;

	assign stat.full  = (count_q == (QAW+1)'(QDEPTH));
	assign stat.empty = (count_q == '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QAW+1)'(QDEPTH)) else $error("queue count out of range");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		stat.full |-> !push) else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		stat.empty |-> !pop) else $error("pop from empty queue");
`endif

endmodule

@@ hw/rtl/tt_back.sv @@
module tt_back (
	input  logic              clk,
	input  logic              arst_n,
	input  tt_pkg::tt_job_t   head,
	input  tt_pkg::tt_qstat_t stat,
	output logic              pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,
	output logic [2:0]        m_tuser,
	output logic              m_tlast
);
	import tt_pkg::*;

	logic phase_q;
	logic load;
	logic slash_beat;

	assign load       = (!m_tvalid || m_tready) && !stat.empty;
	assign slash_beat = head.slash && !phase_q;
	assign pop        = load && !slash_beat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
			phase_q  <= 1'b0;
		end else if (!m_tvalid || m_tready) begin
			m_tvalid <= !stat.empty;
			if (!stat.empty) phase_q <= slash_beat;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (slash_beat) begin
				m_tdata <= CH_SLASH;
				m_tuser <= 3'b001;
				m_tlast <= 1'b0;
			end else begin
				m_tdata <= head.tbyte;
				m_tuser <= {head.send, head.tend, head.bval};
				m_tlast <= 1'b1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_phase_has_job: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> !stat.empty) else $error("slash phase without queued job");
	a_slash_then_main: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> (m_tdata == CH_SLASH && m_tuser == 3'b001))
		else $error("non-final beat is not the pending slash");
	a_marks_only: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tuser[2:1] == 2'b00))
		else $error("mark flags on a data beat");
`endif

endmodule

@@ hw/rtl/text_tokenizer.sv @@
// text_tokenizer
// Input stream s_*: one text byte per beat in s_tdata; a zero byte ends the data.
// Output stream m_*: one beat per token byte or mark. m_tuser[0] flags a token
// byte in m_tdata, m_tuser[1] ends a token, m_tuser[2] ends the stream; m_tlast
// marks the final beat caused by one input byte.
// Config channel cfg_*: cfg_data is signed_chars (reset 1); when set, bytes
// 128..255 count as blanks. Write only while the block is idle.
// Throughput: one input byte per cycle while the job queue is not full. A byte
// that closes a lone '/' gives two output beats; a 4-entry job queue between
// the parser and the output register absorbs these and short receiver stalls.
// A result passes through the job queue and then the output register to m_*.
// When the receiver stalls, the queue fills and s_tready drops when it is full.
// Reset clears the parser to skip mode, empties the queue and the output beat.
module text_tokenizer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] text_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] token_byte
	output logic [2:0] m_tuser,   // [0] byte_valid, [1] token_end, [2] stream_end
	output logic       m_tlast,   // last_of_run
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data   // signed_chars
);
	import tt_pkg::*;

	logic      signed_q;
	logic      accept;
	logic      push;
	logic      pop;
	tt_job_t   job;
	tt_job_t   head;
	tt_qstat_t stat;

	assign cfg_ready = 1'b1;
	assign s_tready  = !stat.full;
	assign accept    = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			signed_q <= 1'b1;
		end else if (cfg_valid) begin
			signed_q <= cfg_data;
		end
	end

	tt_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.text_byte    (s_tdata),
		.signed_chars (signed_q),
		.push         (push),
		.job          (job)
	);

	tt_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (job),
		.pop    (pop),
		.head   (head),
		.stat   (stat)
	);

	tt_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.stat     (stat),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

@@ tb/tb_top.sv @@
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tt_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	localparam logic [7:0] DIRECTED_A [25] = '{
		8'h41, 8'h7E, 8'hFF, 8'h01, 8'h22, 8'h22, 8'h22, 8'h78, 8'h22, 8'h77,
		8'h20, 8'h2F, 8'h71, 8'h0A, 8'h2F, 8'h20, 8'h2F, 8'h2F, 8'h7A, 8'h0A,
		8'h6B, 8'h22, 8'h2F, 8'h2F, 8'h20
	};
	localparam logic [7:0] DIRECTED_B [8] = '{
		8'h80, 8'hFF, 8'h20, 8'h22, 8'hC3, 8'h80, 8'h22, 8'h21
	};

	typedef struct packed {
		logic [7:0] token_byte;
		logic       byte_valid;
		logic       token_end;
		logic       stream_end;
		logic       last_of_run;
	} tok_beat_t;

	class token_tracker;
		tt_mode_t  mode = MODE_SKIP;
		bit        signed_chars = 1'b1;
		tok_beat_t expected_beats[$];
		int        errors = 0;

		function bit is_blank(logic [7:0] c);
			return (c <= CH_SPACE) || (signed_chars && c[7]);
		endfunction

		function void push_beat(logic [7:0] b, logic v, logic te, logic se);
			expected_beats.push_back(tok_beat_t'{b, v, te, se, 1'b0});
		endfunction

		// byte following word characters or a pending slash
		function void word_step(logic [7:0] c);
			if (!is_blank(c)) begin
				mode = MODE_WORD;
				push_beat(c, 1'b1, 1'b0, 1'b0);
			end else if (c == CH_NUL) begin
				mode = MODE_DONE;
				push_beat(8'h00, 1'b0, 1'b1, 1'b1);
			end else begin
				mode = MODE_SKIP;
				push_beat(8'h00, 1'b0, 1'b1, 1'b0);
			end
		endfunction

		function void accept_byte(logic [7:0] c);
			int        n_before;
			tok_beat_t tail;
			n_before = expected_beats.size();
			case (mode)
				MODE_SKIP: begin
					if (c == CH_NUL) begin
						mode = MODE_DONE;
						push_beat(8'h00, 1'b0, 1'b0, 1'b1);
					end else if (is_blank(c)) begin
					end else if (c == CH_SLASH) begin
						mode = MODE_SLASH;
					end else if (c == CH_QUOTE) begin
						mode = MODE_QUOTE;
					end else begin
						mode = MODE_WORD;
						push_beat(c, 1'b1, 1'b0, 1'b0);
					end
				end
				MODE_SLASH: begin
					if (c == CH_SLASH) begin
						mode = MODE_COMMENT;
					end else begin
						push_beat(CH_SLASH, 1'b1, 1'b0, 1'b0);
						word_step(c);
					end
				end
				MODE_COMMENT: begin
					if (c == CH_NUL) begin
						mode = MODE_DONE;
						push_beat(8'h00, 1'b0, 1'b0, 1'b1);
					end else if (c == CH_NL) begin
						mode = MODE_SKIP;
					end
				end
				MODE_QUOTE: begin
					if (c == CH_NUL) begin
						mode = MODE_DONE;
						push_beat(8'h00, 1'b0, 1'b1, 1'b1);
					end else if (c == CH_QUOTE) begin
						mode = MODE_SKIP;
						push_beat(8'h00, 1'b0, 1'b1, 1'b0);
					end else begin
						push_beat(c, 1'b1, 1'b0, 1'b0);
					end
				end
				MODE_WORD: word_step(c);
				default: mode = MODE_DONE;
			endcase
			if (expected_beats.size() > n_before) begin
				tail = expected_beats.pop_back();
				tail.last_of_run = 1'b1;
				expected_beats.push_back(tail);
			end
		endfunction

		function void check_beat(logic [7:0] data, logic [2:0] user, logic last);
			tok_beat_t exp_b;
			if (expected_beats.size() == 0) begin
				$error("beat with nothing expected: token_byte %0h flags %0b last %0b",
					data, user, last);
				errors++;
				return;
			end
			exp_b = expected_beats.pop_front();
			if (data !== exp_b.token_byte) begin
				$error("token_byte: expected %0h, actual %0h", exp_b.token_byte, data);
				errors++;
			end
			if (user[0] !== exp_b.byte_valid) begin
				$error("byte_valid: expected %0b, actual %0b", exp_b.byte_valid, user[0]);
				errors++;
			end
			if (user[1] !== exp_b.token_end) begin
				$error("token_end: expected %0b, actual %0b", exp_b.token_end, user[1]);
				errors++;
			end
			if (user[2] !== exp_b.stream_end) begin
				$error("stream_end: expected %0b, actual %0b", exp_b.stream_end, user[2]);
				errors++;
			end
			if (last !== exp_b.last_of_run) begin
				$error("last_of_run: expected %0b, actual %0b", exp_b.last_of_run, last);
				errors++;
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic [2:0] m_tuser;
	logic       m_tlast;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic       cfg_data = 1'b0;

	token_tracker tracker = new();
	bit           steady = 1'b0;
	int           bytes_sent = 0;
	int           cycle_count = 0;
	int           stall_left = 0;

	text_tokenizer i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	function int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 70)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(6, 25);
	endfunction

	// receiver stalls
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			stall_left = idle_len();
			m_tready <= (stall_left == 0);
			if (stall_left > 0)
				stall_left--;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_beat(m_tdata, m_tuser, m_tlast);
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		tracker.accept_byte(b);
		bytes_sent++;
	endtask

	task automatic write_signed_chars(input logic v);
		s_tvalid <= 1'b0;
		while (tracker.expected_beats.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		tracker.signed_chars = v;
		cfg_valid <= 1'b0;
	endtask

	function logic [7:0] blank_byte();
		case ($urandom_range(0, 3))
			0: return CH_SPACE;
			1: return CH_NL;
			2: return 8'($urandom_range(1, 32));
			default: return 8'($urandom_range(128, 255));
		endcase
	endfunction

	function logic [7:0] text_char();
		return 8'($urandom_range(1, 255));
	endfunction

	task automatic send_word_body(input int n);
		repeat (n) send_byte(8'($urandom_range(33, 255)));
	endtask

	task automatic send_token();
		logic [7:0] b;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				send_byte(8'($urandom_range(8'h30, 8'h7E)));
				send_word_body($urandom_range(0, 6));
			end
			4, 5: begin
				send_byte(CH_QUOTE);
				repeat ($urandom_range(0, 6)) begin
					b = text_char();
					send_byte((b == CH_QUOTE) ? 8'h71 : b);
				end
				send_byte(CH_QUOTE);
			end
			6: begin
				send_byte(CH_SLASH);
				send_byte(CH_SLASH);
				repeat ($urandom_range(0, 8)) begin
					b = text_char();
					send_byte((b == CH_NL) ? 8'h2A : b);
				end
				send_byte(CH_NL);
			end
			7: begin
				send_byte(CH_SLASH);
				if ($urandom_range(0, 1))
					send_word_body($urandom_range(1, 4));
				else
					send_byte(blank_byte());
			end
			default: send_byte(text_char());
		endcase
		if ($urandom_range(0, 9) < 7)
			repeat ($urandom_range(1, 2)) send_byte(blank_byte());
	endtask

	task automatic send_text(input int count);
		int start;
		start = bytes_sent;
		while (bytes_sent - start < count)
			send_token();
	endtask

	// close any open construct, then end the data in a random context
	task automatic end_stream();
		if (tracker.mode == MODE_QUOTE)
			send_byte(CH_QUOTE);
		else if (tracker.mode == MODE_COMMENT)
			send_byte(CH_NL);
		send_byte(CH_SPACE);
		case ($urandom_range(0, 4))
			0: send_byte(CH_SPACE);
			1: send_byte(8'h61);
			2: begin
				send_byte(CH_QUOTE);
				send_byte(8'h61);
			end
			3: begin
				send_byte(CH_SLASH);
				send_byte(CH_SLASH);
				send_byte(8'h61);
			end
			default: send_byte(CH_SLASH);
		endcase
		send_byte(CH_NUL);
		// ignored after the end of data
		repeat (6) send_byte(8'($urandom_range(0, 255)));
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_signed_chars(1'b1);
		foreach (DIRECTED_A[i]) send_byte(DIRECTED_A[i]);
		write_signed_chars(1'b0);
		foreach (DIRECTED_B[i]) send_byte(DIRECTED_B[i]);

		send_text(140);
		write_signed_chars(1'b1);
		steady = 1'b1;
		send_text(60);
		steady = 1'b0;
		send_text(80);
		write_signed_chars(1'b0);
		send_text(105);
		end_stream();

		s_tvalid <= 1'b0;
		while (tracker.expected_beats.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (tracker.errors == 0 && tracker.expected_beats.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/tt_pkg.sv
hw/rtl/tt_front.sv
hw/rtl/tt_queue.sv
hw/rtl/tt_back.sv
hw/rtl/text_tokenizer.sv
tb/tb_top.sv
